[rtl/jdm_pkg.sv]
package jdm_pkg;

  localparam int DEADBAND_W   = 15;
  localparam int DUTY_W       = 8;
  localparam int AXIS_W       = 16;
  localparam int HIST_W       = 4;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 15;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 24;

  localparam logic [AXIS_W-1:0]     AXIS_CENTER      = 16'h8000;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET   = 15'd512;
  localparam logic [DUTY_W-1:0]     BRAKE_DUTY_RESET = 8'd217;
  localparam logic [DUTY_W-1:0]     DUTY_MAX         = 8'hff;

  // Newest sample in bit 0: on, on, off, off.
  localparam logic [HIST_W-1:0]     PRESS_PATTERN    = 4'b0011;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRAKE_DUTY = 1'b1;

  typedef struct packed {
    logic down;
    logic light;
    logic reset_btn;
    logic up;
    logic brake;
  } button_set_t;

  typedef struct packed {
    logic down_out;
    logic up_out;
    logic light_out;
    logic reset_out;
    logic brake_latch;
  } button_out_t;

  typedef struct packed {
    logic              pos;
    logic              neg;
    logic [DUTY_W-1:0] mag;
  } axis_zone_t;

  typedef struct packed {
    logic              brake_left;
    logic              brake_right;
    logic [DUTY_W-1:0] duty_one;
    logic [DUTY_W-1:0] duty_two;
  } drive_cmd_t;

endpackage

[rtl/jdm_axis.sv]
module jdm_axis (
  input  logic [jdm_pkg::AXIS_W-1:0]     axis,
  input  logic [jdm_pkg::DEADBAND_W-1:0] deadband,
  output jdm_pkg::axis_zone_t            zone
);

  logic signed [jdm_pkg::AXIS_W-1:0] offset;
  logic signed [jdm_pkg::AXIS_W:0]   offset_w;
  logic signed [jdm_pkg::AXIS_W:0]   db_w;
  logic [jdm_pkg::AXIS_W-1:0]        abs_val;

  // Subtracting the center is the same as flipping the top bit.
  assign offset   = signed'(axis ^ jdm_pkg::AXIS_CENTER);
  assign offset_w = {offset[jdm_pkg::AXIS_W-1], offset};
  assign db_w     = signed'({2'b00, deadband});
  assign abs_val  = offset[jdm_pkg::AXIS_W-1] ? (~unsigned'(offset) + 16'd1)
                                              : unsigned'(offset);

  always_comb begin
    zone.pos = offset_w > db_w;
    zone.neg = offset_w < -db_w;
    zone.mag = abs_val[jdm_pkg::AXIS_W-1] ? jdm_pkg::DUTY_MAX : abs_val[14:7];
  end

endmodule

[rtl/jdm_buttons.sv]
module jdm_buttons (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  jdm_pkg::button_set_t btn,
  output jdm_pkg::button_out_t lines
);

  logic                        prev_up;
  logic                        prev_down;
  logic [jdm_pkg::HIST_W-1:0]  light_history;
  logic [jdm_pkg::HIST_W-1:0]  brake_history;
  logic [jdm_pkg::HIST_W-1:0]  reset_history;
  logic [jdm_pkg::HIST_W-1:0]  light_history_next;
  logic [jdm_pkg::HIST_W-1:0]  brake_history_next;
  logic [jdm_pkg::HIST_W-1:0]  reset_history_next;

  assign light_history_next = {light_history[jdm_pkg::HIST_W-2:0], btn.light};
  assign brake_history_next = {brake_history[jdm_pkg::HIST_W-2:0], btn.brake};
  assign reset_history_next = {reset_history[jdm_pkg::HIST_W-2:0], btn.reset_btn};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_up       <= 1'b0;
      prev_down     <= 1'b0;
      light_history <= '0;
      brake_history <= '0;
      reset_history <= '0;
      lines         <= '0;
    end else if (en) begin
      prev_up       <= btn.up;
      prev_down     <= btn.down;
      light_history <= light_history_next;
      brake_history <= brake_history_next;
      reset_history <= reset_history_next;
      if (prev_down == btn.down) begin
        lines.down_out <= btn.down;
      end
      if (prev_up == btn.up) begin
        lines.up_out <= btn.up;
      end
      if (light_history_next == jdm_pkg::PRESS_PATTERN) begin
        lines.light_out <= ~lines.light_out;
      end
      if (brake_history_next == jdm_pkg::PRESS_PATTERN) begin
        lines.brake_latch <= ~lines.brake_latch;
      end
      if (reset_history_next == jdm_pkg::PRESS_PATTERN) begin
        lines.reset_out <= ~lines.reset_out;
      end
    end
  end

endmodule

[rtl/jdm_mix.sv]
module jdm_mix (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [jdm_pkg::DEADBAND_W-1:0] deadband,
  input  logic [jdm_pkg::DUTY_W-1:0]     brake_duty,
  input  logic [jdm_pkg::AXIS_W-1:0]     drive_axis,
  input  logic [jdm_pkg::AXIS_W-1:0]     steer_axis,
  output jdm_pkg::drive_cmd_t            cmd
);

  jdm_pkg::axis_zone_t          drive_zone;
  jdm_pkg::axis_zone_t          steer_zone;
  jdm_pkg::drive_cmd_t          cmd_next;
  logic                         prev_center;
  logic                         prev_neutral;
  logic                         prev_right;
  logic                         prev_left;
  logic                         center;
  logic                         neutral;
  logic [jdm_pkg::DUTY_W-1:0]   speed_value;
  logic [jdm_pkg::DUTY_W-1:0]   steer_value;
  logic [jdm_pkg::DUTY_W-1:0]   speed_value_next;
  logic [jdm_pkg::DUTY_W-1:0]   steer_value_next;

  jdm_axis u_drive_axis (
    .axis     (drive_axis),
    .deadband (deadband),
    .zone     (drive_zone)
  );

  jdm_axis u_steer_axis (
    .axis     (steer_axis),
    .deadband (deadband),
    .zone     (steer_zone)
  );

  assign neutral = ~(drive_zone.pos | drive_zone.neg);
  assign center  = ~(steer_zone.pos | steer_zone.neg);
  assign speed_value_next = neutral ? speed_value : drive_zone.mag;
  assign steer_value_next = center  ? steer_value : steer_zone.mag;

  always_comb begin
    cmd_next = cmd;
    if (prev_center && center && prev_neutral && neutral) begin
      cmd_next = '{brake_left: 1'b1, brake_right: 1'b1,
                   duty_one: brake_duty, duty_two: brake_duty};
    end else if (prev_center && center) begin
      cmd_next = '{brake_left: 1'b0, brake_right: 1'b0,
                   duty_one: speed_value_next, duty_two: speed_value_next};
    end else if (prev_right && steer_zone.neg) begin
      cmd_next = '{brake_left: 1'b0, brake_right: 1'b1,
                   duty_one: speed_value_next, duty_two: steer_value_next};
    end else if (prev_left && steer_zone.pos) begin
      cmd_next = '{brake_left: 1'b1, brake_right: 1'b0,
                   duty_one: steer_value_next, duty_two: speed_value_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_center  <= 1'b0;
      prev_neutral <= 1'b0;
      prev_right   <= 1'b0;
      prev_left    <= 1'b0;
      speed_value  <= '0;
      steer_value  <= '0;
      cmd          <= '0;
    end else if (en) begin
      prev_center  <= center;
      prev_neutral <= neutral;
      prev_right   <= steer_zone.neg;
      prev_left    <= steer_zone.pos;
      speed_value  <= speed_value_next;
      steer_value  <= steer_value_next;
      cmd          <= cmd_next;
    end
  end

endmodule

[rtl/joystick_drive_mixer_top.sv]
// Joystick drive mixer: turns received command frames into line and PWM
// duty commands for a two-wheel drive.
// Each item on the input stream is one valid frame; each frame yields exactly
// one item on the output stream carrying the full set of output lines.
// A frame is captured in an input register; the button, axis and mode logic
// then loads the held output state, which is what the output stream presents.
// One item per cycle is accepted as long as the receiver takes items; the
// input side stays ready while a finished item waits if the input register
// is empty, so at most one frame is buffered behind a stalled output.
// When the receiver stalls, the held state does not move and the input
// register fills, after which s_axis_tready drops until the output is taken.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0: deadband, 1: brake duty); write only while no item is in flight.
// Reset (rst, synchronous) empties both stages, clears all history and
// held outputs, and loads deadband 512 and brake duty 217.
module joystick_drive_mixer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // down_button, light_button, reset_button, up_button, brake_button,
  // drive_axis[15:0], steer_axis[15:0], zero fill
  input  logic [jdm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // down_out, up_out, light_out, reset_out, brake_latch, brake_left,
  // brake_right, duty_one[7:0], duty_two[7:0], zero fill
  output logic [jdm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [jdm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [jdm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                           in_valid;
  logic [36:0]                    in_data;
  logic                           advance;
  logic [jdm_pkg::DEADBAND_W-1:0] deadband;
  logic [jdm_pkg::DUTY_W-1:0]     brake_duty;
  jdm_pkg::button_set_t           btn;
  jdm_pkg::button_out_t           lines;
  jdm_pkg::drive_cmd_t            cmd;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata[36:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband   <= jdm_pkg::DEADBAND_RESET;
      brake_duty <= jdm_pkg::BRAKE_DUTY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jdm_pkg::CFG_DEADBAND:   deadband   <= cfg_data;
        jdm_pkg::CFG_BRAKE_DUTY: brake_duty <= cfg_data[jdm_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign btn = '{down: in_data[0], light: in_data[1], reset_btn: in_data[2],
                 up: in_data[3], brake: in_data[4]};

  jdm_buttons u_buttons (
    .clk   (clk),
    .rst   (rst),
    .en    (advance),
    .btn   (btn),
    .lines (lines)
  );

  jdm_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .deadband   (deadband),
    .brake_duty (brake_duty),
    .drive_axis (in_data[20:5]),
    .steer_axis (in_data[36:21]),
    .cmd        (cmd)
  );

  assign m_axis_tdata = {1'b0, cmd.duty_two, cmd.duty_one, cmd.brake_right,
                         cmd.brake_left, lines.brake_latch, lines.reset_out,
                         lines.light_out, lines.up_out, lines.down_out};

`ifndef SYNTHESIS
  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input side stalled while the output slot is free");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input side stalled without a buffered item");

  a_brake_duty_match: assert property (@(posedge clk) disable iff (rst)
    cmd.brake_left && cmd.brake_right |-> cmd.duty_one == cmd.duty_two)
    else $error("both brakes set with unequal duties");

  a_result_follows_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("processed item not presented on the output");
`endif

endmodule

[bench/joystick_drive_mixer_top_tb.sv]
`timescale 1ns / 1ps

module joystick_drive_mixer_top_tb;
  import jdm_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE          = 8;
  localparam int PHASES          = 5;
  localparam int RANDOM_PHASE    = 3;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int PRESSURE_AT     = 150;
  localparam int PRESSURE_CYCLES = 64;
  localparam int DIR_ROWS        = 16;

  localparam int PHASE_DEADBAND [PHASES]   = '{0, 32767, 1, 0, 512};
  localparam int PHASE_BRAKE_DUTY [PHASES] = '{0, 255, 128, 0, 217};

  typedef enum logic [1:0] {ZONE_CENTER, ZONE_POS, ZONE_NEG} zone_t;

  typedef struct packed {
    logic [AXIS_W-1:0] steer;
    logic [AXIS_W-1:0] drive;
    logic              brake;
    logic              up;
    logic              reset_btn;
    logic              light;
    logic              down;
  } frame_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_two;
    logic [DUTY_W-1:0] duty_one;
    logic              brake_right;
    logic              brake_left;
    logic              brake_latch;
    logic              reset_out;
    logic              light_out;
    logic              up_out;
    logic              down_out;
  } result_t;

  typedef struct packed {
    logic              down;
    logic              light;
    logic              reset_btn;
    logic              up;
    logic              brake;
    logic [AXIS_W-1:0] drive;
    logic [AXIS_W-1:0] steer;
    logic              known;
    result_t           want;
  } stim_row_t;

  localparam result_t ALL_LOW    = '0;
  localparam result_t FROM_MODEL = '0;
  localparam result_t BRAKED_AT_REST = '{BRAKE_DUTY_RESET, BRAKE_DUTY_RESET,
                                         1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam result_t FULL_SPEED = '{DUTY_MAX, DUTY_MAX,
                                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  // Columns: down, light, reset, up, brake, drive, steer, known, expected.
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h8000, 1'b1, ALL_LOW},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h8000, 1'b1, BRAKED_AT_REST},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h8000, 1'b1, FULL_SPEED},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'hffff, 16'h8000, 1'b1, FULL_SPEED},
    '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'h8000, 16'h0000, 1'b0, FROM_MODEL},
    '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'h8000, 16'h0001, 1'b0, FROM_MODEL},
    '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 16'h8201, 16'hffff, 1'b0, FROM_MODEL},
    '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'h7dff, 16'hfffe, 1'b0, FROM_MODEL},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h8200, 16'h8200, 1'b0, FROM_MODEL},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h7e00, 16'h7e00, 1'b0, FROM_MODEL},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h7e00, 16'h8201, 1'b0, FROM_MODEL},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h7dff, 1'b0, FROM_MODEL},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'h8000, 16'h8000, 1'b0, FROM_MODEL},
    '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 16'hffff, 16'h8000, 1'b0, FROM_MODEL},
    '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 16'h0001, 16'h8000, 1'b0, FROM_MODEL},
    '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'h8000, 16'h8000, 1'b0, FROM_MODEL}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_DEADBAND;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  joystick_drive_mixer_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  logic [DEADBAND_W-1:0] cur_deadband;
  logic [DUTY_W-1:0]     cur_brake_duty;
  logic                  last_up, last_down;
  logic [HIST_W-1:0]     light_hist, brake_hist, reset_hist;
  logic                  was_center, was_neutral, was_right, was_left;
  logic [DUTY_W-1:0]     speed_mag, steer_mag;
  result_t               held;

  result_t expected_q [$];
  result_t seen, want;
  int errors = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int rest_brakes = 0;
  int right_turns = 0;
  int left_turns = 0;
  int cycle_count = 0;
  bit send_calm = 1'b0;

  function automatic int idle_len();
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic zone_t classify_axis(input logic [AXIS_W-1:0] axis,
                                          output logic [DUTY_W-1:0] mag);
    int off, db, m;
    off = int'(axis) - int'(AXIS_CENTER);
    db = int'(cur_deadband);
    mag = '0;
    if (off > db) begin
      m = off;
    end else if (off < -db) begin
      m = -off;
    end else begin
      return ZONE_CENTER;
    end
    m = m >> 7;
    mag = (m > int'(DUTY_MAX)) ? DUTY_MAX : m[DUTY_W-1:0];
    return (off > 0) ? ZONE_POS : ZONE_NEG;
  endfunction

  function automatic result_t mix_frame(input frame_t f);
    logic [DUTY_W-1:0] mag;
    zone_t dz, sz;
    logic neutral, center;
    if (last_down == f.down) held.down_out = f.down;
    if (last_up == f.up) held.up_out = f.up;
    last_down = f.down;
    last_up = f.up;
    light_hist = {light_hist[HIST_W-2:0], f.light};
    brake_hist = {brake_hist[HIST_W-2:0], f.brake};
    reset_hist = {reset_hist[HIST_W-2:0], f.reset_btn};
    if (light_hist == PRESS_PATTERN) held.light_out = ~held.light_out;
    if (brake_hist == PRESS_PATTERN) held.brake_latch = ~held.brake_latch;
    if (reset_hist == PRESS_PATTERN) held.reset_out = ~held.reset_out;
    dz = classify_axis(f.drive, mag);
    if (dz != ZONE_CENTER) speed_mag = mag;
    sz = classify_axis(f.steer, mag);
    if (sz != ZONE_CENTER) steer_mag = mag;
    neutral = (dz == ZONE_CENTER);
    center = (sz == ZONE_CENTER);
    if (was_center && center && was_neutral && neutral) begin
      held.brake_left = 1'b1;
      held.brake_right = 1'b1;
      held.duty_one = cur_brake_duty;
      held.duty_two = cur_brake_duty;
    end else if (was_center && center) begin
      held.brake_left = 1'b0;
      held.brake_right = 1'b0;
      held.duty_one = speed_mag;
      held.duty_two = speed_mag;
    end else if (was_right && sz == ZONE_NEG) begin
      held.brake_left = 1'b0;
      held.brake_right = 1'b1;
      held.duty_one = speed_mag;
      held.duty_two = steer_mag;
    end else if (was_left && sz == ZONE_POS) begin
      held.brake_left = 1'b1;
      held.brake_right = 1'b0;
      held.duty_one = steer_mag;
      held.duty_two = speed_mag;
    end
    was_center = center;
    was_neutral = neutral;
    was_right = (sz == ZONE_NEG);
    was_left = (sz == ZONE_POS);
    return held;
  endfunction

  // Picks a position in the given zone if it has one, often at its edges.
  function automatic logic [AXIS_W-1:0] pick_axis(input zone_t z);
    int db, off;
    db = int'(cur_deadband);
    if (z == ZONE_POS && db < 32767) begin
      case ($urandom_range(7))
        0: off = db + 1;
        1: off = 32767;
        default: off = int'($urandom_range(32767, db + 1));
      endcase
    end else if (z == ZONE_NEG) begin
      case ($urandom_range(7))
        0: off = -db - 1;
        1: off = -32768;
        default: off = -int'($urandom_range(32768, db + 1));
      endcase
    end else begin
      case ($urandom_range(7))
        0: off = db;
        1: off = -db;
        default: off = int'($urandom_range(2 * db, 0)) - db;
      endcase
    end
    off = off + 32768;
    return off[AXIS_W-1:0];
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic offer_frame(input frame_t f, input logic known, input result_t typed_want);
    result_t predicted;
    logic [63:0] noise;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W - $bits(frame_t)){1'b0}}, f};
    do @(posedge clk); while (!s_axis_tready);
    predicted = mix_frame(f);
    expected_q.push_back(known ? typed_want : predicted);
    frames_sent++;
    if (!send_calm && $urandom_range(3) == 0) begin
      noise = {$urandom(), $urandom()};
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= noise[IN_TDATA_W-1:0];
      repeat (idle_len()) @(posedge clk);
    end
    if ($urandom_range(49) == 0) send_calm = !send_calm;
  endtask

  task automatic set_registers(input logic [DEADBAND_W-1:0] db, input logic [DUTY_W-1:0] bd);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEADBAND;
    cfg_data <= db;
    @(posedge clk);
    cfg_index <= CFG_BRAKE_DUTY;
    cfg_data <= {{(CFG_DATA_W - DUTY_W){1'b0}}, bd};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_deadband = db;
    cur_brake_duty = bd;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      results_seen++;
      if (seen.brake_left && seen.brake_right) rest_brakes++;
      if (seen.brake_right && !seen.brake_left) right_turns++;
      if (seen.brake_left && !seen.brake_right) left_turns++;
      if (expected_q.size() == 0) begin
        $display("%0t: result expected none, got %h", $time, seen);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("down_out", int'(want.down_out), int'(seen.down_out));
        check_field("up_out", int'(want.up_out), int'(seen.up_out));
        check_field("light_out", int'(want.light_out), int'(seen.light_out));
        check_field("reset_out", int'(want.reset_out), int'(seen.reset_out));
        check_field("brake_latch", int'(want.brake_latch), int'(seen.brake_latch));
        check_field("brake_left", int'(want.brake_left), int'(seen.brake_left));
        check_field("brake_right", int'(want.brake_right), int'(seen.brake_right));
        check_field("duty_one", int'(want.duty_one), int'(seen.duty_one));
        check_field("duty_two", int'(want.duty_two), int'(seen.duty_two));
      end
    end
  end

  initial begin : drain
    int gap;
    bit calm, held_off;
    gap = 0;
    calm = 1'b0;
    held_off = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held_off && results_seen >= PRESSURE_AT) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end else if (gap > 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(3) == 0) gap = idle_len();
      end
      if ($urandom_range(99) == 0) calm = !calm;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("joystick_drive_mixer_top_tb: errors");
    $finish;
  end

  initial begin : stimulus
    frame_t f;
    stim_row_t r;
    zone_t drive_zone, steer_zone;
    logic [63:0] noise;
    logic [DEADBAND_W-1:0] next_db;
    logic [DUTY_W-1:0] next_bd;
    int pick;
    cur_deadband = DEADBAND_RESET;
    cur_brake_duty = BRAKE_DUTY_RESET;
    last_up = 1'b0;
    last_down = 1'b0;
    light_hist = '0;
    brake_hist = '0;
    reset_hist = '0;
    was_center = 1'b0;
    was_neutral = 1'b0;
    was_right = 1'b0;
    was_left = 1'b0;
    speed_mag = '0;
    steer_mag = '0;
    held = '0;
    drive_zone = ZONE_CENTER;
    steer_zone = ZONE_CENTER;
    f = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      r = DIRECTED[i];
      f = {r.steer, r.drive, r.brake, r.up, r.reset_btn, r.light, r.down};
      offer_frame(f, r.known, r.want);
    end

    for (int p = 0; p < PHASES; p++) begin
      s_axis_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
      if (p == RANDOM_PHASE) begin
        pick = $urandom_range(32767);
        next_db = pick[DEADBAND_W-1:0];
        pick = $urandom_range(255);
        next_bd = pick[DUTY_W-1:0];
      end else begin
        pick = PHASE_DEADBAND[p];
        next_db = pick[DEADBAND_W-1:0];
        pick = PHASE_BRAKE_DUTY[p];
        next_bd = pick[DUTY_W-1:0];
      end
      set_registers(next_db, next_bd);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(9) == 0) begin
          noise = {$urandom(), $urandom()};
          f = frame_t'(noise[$bits(frame_t)-1:0]);
        end else begin
          if ($urandom_range(3) == 0) drive_zone = zone_t'($urandom_range(2));
          if ($urandom_range(3) == 0) steer_zone = zone_t'($urandom_range(2));
          f.drive = pick_axis(drive_zone);
          f.steer = pick_axis(steer_zone);
          f.down = f.down ^ ($urandom_range(3) == 0);
          f.up = f.up ^ ($urandom_range(3) == 0);
          f.light = f.light ^ ($urandom_range(3) == 0);
          f.brake = f.brake ^ ($urandom_range(3) == 0);
          f.reset_btn = f.reset_btn ^ ($urandom_range(3) == 0);
        end
        offer_frame(f, 1'b0, FROM_MODEL);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d frames and checked %0d results under %0d register settings.",
             frames_sent, results_seen, PHASES + 1);
    $display("Results seen: %0d braked at rest, %0d right turn, %0d left turn.",
             rest_brakes, right_turns, left_turns);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("joystick_drive_mixer_top_tb: clean");
    end else begin
      $display("joystick_drive_mixer_top_tb: errors");
    end
    $finish;
  end

endmodule
